// File: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// Point-to-segment distance package
// Shared widths, item types and helpers of the point-to-segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RAD_W   = SUM_W + (SUM_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int U_FRAC  = 32;
  localparam int MUL_W   = U_FRAC + 1 + DIFF_W;
  localparam int DIST_W  = 33;

  typedef logic [1:0] region_t;

  localparam region_t REGION_INTERIOR = 2'd0;
  localparam region_t REGION_START    = 2'd1;
  localparam region_t REGION_END      = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
    logic [DIST_W-1:0]         distance;
    region_t                   region;
  } out_item_t;

  function automatic logic [DIFF_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return r;
  endfunction

endpackage

// File: rtl/point_segment_distance_core.sv
// ----------------------------------------------------------------------------
// Point-to-segment distance core
// Finds the point of segment AB nearest to a query point and its distance.
//
// The item channel (item_valid, item_ready, item) carries a query point and
// the two segment endpoints in signed Q16.16. The result channel
// (result_valid, result_ready, result) returns the nearest point, the
// Euclidean distance in unsigned Q17.16 and a region code: interior,
// clamped to the start point, or clamped to the end point.
// One item is taken every cycle while item_ready is high; the depth comes
// from the 32-stage divider that forms the projection and the 34-stage
// square root.
// Reset empties the pipeline and the output buffer. When the receiver
// stalls, a skid register behind the output register still takes one more
// item; after that the whole pipeline holds and item_ready goes low until
// the output drains.
// ----------------------------------------------------------------------------
module point_segment_distance_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  psd_pkg::in_item_t item,
  output logic              result_valid,
  input  logic              result_ready,
  output psd_pkg::out_item_t result
);
  import psd_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    region_t                   region;
    logic                      unit;
  } div_tag_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    region_t                   region;
  } sqrt_tag_t;

  logic en;
  logic skid_valid;
  out_item_t skid;

  // stage 1: differences
  logic v1;
  logic signed [COORD_W-1:0] ax1, ay1, bx1, by1, qx1, qy1;
  logic signed [DIFF_W-1:0]  dx1, dy1, px1, py1;
  // stage 2: products
  logic v2;
  logic signed [COORD_W-1:0] ax2, ay2, bx2, by2, qx2, qy2;
  logic signed [DIFF_W-1:0]  dx2, dy2;
  logic signed [PROD_W-1:0]  pdx2, pdy2, ddx2, ddy2;
  // stage 3: sums
  logic v3;
  logic signed [COORD_W-1:0] ax3, ay3, bx3, by3, qx3, qy3;
  logic signed [DIFF_W-1:0]  dx3, dy3;
  logic signed [SUM_W-1:0]   num3;
  logic [PROD_W-1:0]         den3;
  // stage 4: classification
  logic v4;
  div_tag_t tag4;
  logic [PROD_W-1:0] num4, den4;

  logic div_valid;
  logic [U_FRAC-1:0] div_quo;
  logic [$bits(div_tag_t)-1:0] div_tag_raw;
  div_tag_t div_tag;

  // stage 5: offsets along the segment
  logic v5;
  div_tag_t tag5;
  logic [MUL_W-1:0] mx5, my5;
  logic [U_FRAC:0] qv;
  // stage 6: nearest point
  logic v6;
  logic signed [COORD_W-1:0] cx6, cy6, qx6, qy6;
  region_t reg6;
  logic [MUL_W-1:0] rx, ry;
  logic [DIFF_W-1:0] ox, oy, sox, soy;
  logic [DIFF_W-1:0] nx, ny;
  // stage 7: error vector
  logic v7;
  sqrt_tag_t tag7;
  logic signed [DIFF_W-1:0] ex7, ey7;
  // stage 8: squares
  logic v8;
  sqrt_tag_t tag8;
  logic signed [PROD_W-1:0] eex8, eey8;
  // stage 9: radicand
  logic v9;
  sqrt_tag_t tag9;
  logic [RAD_W-1:0] rad9;

  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic sq_up;
  logic [$bits(sqrt_tag_t)-1:0] sq_tag_raw;
  sqrt_tag_t sq_tag;

  // stage 10: rounding and saturation
  logic v10;
  out_item_t res10;
  logic [ROOT_W:0] dist_round;

  assign en         = !skid_valid;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      ax1 <= item.start_x;
      ay1 <= item.start_y;
      bx1 <= item.end_x;
      by1 <= item.end_y;
      qx1 <= item.query_x;
      qy1 <= item.query_y;
      dx1 <= {item.end_x[COORD_W-1], item.end_x} - {item.start_x[COORD_W-1], item.start_x};
      dy1 <= {item.end_y[COORD_W-1], item.end_y} - {item.start_y[COORD_W-1], item.start_y};
      px1 <= {item.query_x[COORD_W-1], item.query_x}
             - {item.start_x[COORD_W-1], item.start_x};
      py1 <= {item.query_y[COORD_W-1], item.query_y}
             - {item.start_y[COORD_W-1], item.start_y};

      ax2  <= ax1;
      ay2  <= ay1;
      bx2  <= bx1;
      by2  <= by1;
      qx2  <= qx1;
      qy2  <= qy1;
      dx2  <= dx1;
      dy2  <= dy1;
      pdx2 <= PROD_W'(px1) * PROD_W'(dx1);
      pdy2 <= PROD_W'(py1) * PROD_W'(dy1);
      ddx2 <= PROD_W'(dx1) * PROD_W'(dx1);
      ddy2 <= PROD_W'(dy1) * PROD_W'(dy1);

      ax3  <= ax2;
      ay3  <= ay2;
      bx3  <= bx2;
      by3  <= by2;
      qx3  <= qx2;
      qy3  <= qy2;
      dx3  <= dx2;
      dy3  <= dy2;
      num3 <= SUM_W'(pdx2) + SUM_W'(pdy2);
      den3 <= PROD_W'($unsigned(ddx2) + $unsigned(ddy2));

      tag4.ax   <= ax3;
      tag4.ay   <= ay3;
      tag4.bx   <= bx3;
      tag4.by   <= by3;
      tag4.qx   <= qx3;
      tag4.qy   <= qy3;
      tag4.dx   <= dx3;
      tag4.dy   <= dy3;
      tag4.unit <= num3[PROD_W-1:0] == den3;
      if (den3 == '0 || num3[SUM_W-1]) begin
        tag4.region <= REGION_START;
      end else if (num3[PROD_W-1:0] > den3) begin
        tag4.region <= REGION_END;
      end else begin
        tag4.region <= REGION_INTERIOR;
      end
      num4 <= num3[PROD_W-1:0];
      den4 <= den3;
    end
  end

  psd_div #(
    .DEN_W (PROD_W),
    .Q_W   (U_FRAC),
    .TAG_W ($bits(div_tag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_num    (num4),
    .in_den    (den4),
    .in_tag    (tag4),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_tag   (div_tag_raw)
  );

  assign div_tag = div_tag_raw;
  assign qv = div_tag.unit ? ((U_FRAC+1)'(1) << U_FRAC) : {1'b0, div_quo};

  assign rx  = mx5 + (MUL_W'(1) << (U_FRAC - 1));
  assign ry  = my5 + (MUL_W'(1) << (U_FRAC - 1));
  assign ox  = rx[U_FRAC +: DIFF_W];
  assign oy  = ry[U_FRAC +: DIFF_W];
  assign sox = tag5.dx[DIFF_W-1] ? DIFF_W'(-ox) : ox;
  assign soy = tag5.dy[DIFF_W-1] ? DIFF_W'(-oy) : oy;
  assign nx  = {tag5.ax[COORD_W-1], tag5.ax} + sox;
  assign ny  = {tag5.ay[COORD_W-1], tag5.ay} + soy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v5 <= div_valid;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
    if (en) begin
      tag5 <= div_tag;
      mx5  <= MUL_W'(qv) * MUL_W'(diff_mag(div_tag.dx));
      my5  <= MUL_W'(qv) * MUL_W'(diff_mag(div_tag.dy));

      qx6  <= tag5.qx;
      qy6  <= tag5.qy;
      reg6 <= tag5.region;
      case (tag5.region)
        REGION_INTERIOR: begin
          cx6 <= nx[COORD_W-1:0];
          cy6 <= ny[COORD_W-1:0];
        end
        REGION_END: begin
          cx6 <= tag5.bx;
          cy6 <= tag5.by;
        end
        default: begin
          cx6 <= tag5.ax;
          cy6 <= tag5.ay;
        end
      endcase

      tag7.cx     <= cx6;
      tag7.cy     <= cy6;
      tag7.region <= reg6;
      ex7 <= {qx6[COORD_W-1], qx6} - {cx6[COORD_W-1], cx6};
      ey7 <= {qy6[COORD_W-1], qy6} - {cy6[COORD_W-1], cy6};

      tag8 <= tag7;
      eex8 <= PROD_W'(ex7) * PROD_W'(ex7);
      eey8 <= PROD_W'(ey7) * PROD_W'(ey7);

      tag9 <= tag8;
      rad9 <= RAD_W'($unsigned(eex8)) + RAD_W'($unsigned(eey8));
    end
  end

  psd_sqrt #(
    .RAD_W (RAD_W),
    .TAG_W ($bits(sqrt_tag_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .in_rad    (rad9),
    .in_tag    (tag9),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_up    (sq_up),
    .out_tag   (sq_tag_raw)
  );

  assign sq_tag     = sq_tag_raw;
  assign dist_round = {1'b0, sq_root} + (ROOT_W+1)'(sq_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= sq_valid;
    end
    if (en) begin
      res10.nearest_x <= sq_tag.cx;
      res10.nearest_y <= sq_tag.cy;
      res10.region    <= sq_tag.region;
      res10.distance  <= (dist_round[ROOT_W:DIST_W] != '0) ? '1
                         : dist_round[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_ready || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= v10;
      end
    end else if (v10 && en) begin
      skid_valid <= 1'b1;
    end
    if (result_ready || !result_valid) begin
      result <= skid_valid ? skid : res10;
    end else if (v10 && en) begin
      skid <= res10;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register full while output register is empty");

  a_skid_stalls: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !item_ready)
    else $error("item accepted while skid register is full");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && !result_ready && v10))
    else $error("skid register filled without a stalled result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && result_ready |=> !skid_valid && result_valid)
    else $error("skid register did not drain into output register");

endmodule

// File: rtl/psd_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage for a numerator below the denominator.
// ----------------------------------------------------------------------------
module psd_div #(
  parameter int DEN_W = 66,
  parameter int Q_W   = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld [Q_W+1];
  logic [DEN_W-1:0] rem [Q_W+1];
  logic [DEN_W-1:0] den [Q_W+1];
  logic [Q_W-1:0]   quo [Q_W+1];
  logic [TAG_W-1:0] tag [Q_W+1];

  assign vld[0] = in_valid;
  assign rem[0] = in_num;
  assign den[0] = in_den;
  assign quo[0] = '0;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W:0] shl;
    logic [DEN_W:0] dif;
    logic           ge;

    assign shl = {rem[k], 1'b0};
    assign dif = shl - {1'b0, den[k]};
    assign ge  = shl >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1] <= ge ? dif[DEN_W-1:0] : shl[DEN_W-1:0];
        quo[k+1] <= {quo[k][Q_W-2:0], ge};
        den[k+1] <= den[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo   = quo[Q_W];
  assign out_tag   = tag[Q_W];

endmodule

// File: rtl/psd_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage; reports the floor root and whether to round up.
// ----------------------------------------------------------------------------
module psd_sqrt #(
  parameter int RAD_W = 68,
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   out_root,
  output logic                 out_up,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int STEPS = RAD_W / 2;

  logic             vld [STEPS+1];
  logic [RAD_W-1:0] rad [STEPS+1];
  logic [RAD_W-1:0] res [STEPS+1];
  logic [TAG_W-1:0] tag [STEPS+1];

  assign vld[0] = in_valid;
  assign rad[0] = in_rad;
  assign res[0] = '0;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] t;
    logic             ge;

    assign t  = res[k] + BIT;
    assign ge = rad[k] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rad[k+1] <= ge ? rad[k] - t : rad[k];
        res[k+1] <= (res[k] >> 1) + (ge ? BIT : '0);
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = res[STEPS][STEPS-1:0];
  assign out_up    = rad[STEPS] > res[STEPS];
  assign out_tag   = tag[STEPS];

endmodule

// File: dv/point_segment_distance_core_tb.sv
// ----------------------------------------------------------------------------
// Point-to-segment distance core testbench
// Drives queries and segments through the item channel with random gaps,
// stalls the result channel at random and checks every result field against
// an exact wide-integer prediction of the nearest point, region and distance.
// ----------------------------------------------------------------------------
module point_segment_distance_core_tb;

  import psd_pkg::*;

  typedef logic signed [135:0] wide_t;

  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh80000000;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  out_item_t expected_results[$];
  int        errors;
  int        items_sent;
  int        results_seen;
  int        region_count[3];
  bit        no_idle;

  point_segment_distance_core DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 3_000_000);
    $display("Timeout at %0t with %0d results outstanding", $time, expected_results.size());
    $display("point_segment_distance_core_tb: FAIL");
    $finish;
  end

  function automatic wide_t offset_along(wide_t d, wide_t q);
    wide_t m;
    wide_t o;
    m = (d < 0) ? -d : d;
    o = (q * m + (wide_t'(1) <<< (U_FRAC - 1))) >>> U_FRAC;
    return (d < 0) ? -o : o;
  endfunction

  function automatic out_item_t nearest_on_segment(in_item_t it);
    wide_t qx, qy, ax, ay, bx, by, dx, dy, px, py;
    wide_t num, den, q, cx, cy, ex, ey, s, r, t;
    out_item_t o;
    qx = it.query_x; qy = it.query_y;
    ax = it.start_x; ay = it.start_y;
    bx = it.end_x;   by = it.end_y;
    dx = bx - ax; dy = by - ay;
    px = qx - ax; py = qy - ay;
    num = px * dx + py * dy;
    den = dx * dx + dy * dy;
    if (den == 0 || num < 0) begin
      cx = ax; cy = ay; o.region = REGION_START;
    end else if (num > den) begin
      cx = bx; cy = by; o.region = REGION_END;
    end else begin
      if (num == den) q = wide_t'(1) <<< U_FRAC;
      else q = (num <<< U_FRAC) / den;
      cx = ax + offset_along(dx, q);
      cy = ay + offset_along(dy, q);
      o.region = REGION_INTERIOR;
    end
    ex = qx - cx; ey = qy - cy;
    s = ex * ex + ey * ey;
    r = 0;
    for (int i = 40; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r = r + 1;
    if (r > wide_t'((64'd1 << DIST_W) - 1)) r = wide_t'((64'd1 << DIST_W) - 1);
    o.nearest_x = cx[COORD_W-1:0];
    o.nearest_y = cy[COORD_W-1:0];
    o.distance  = r[DIST_W-1:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_query(in_item_t it);
    int gap;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!(item_valid && item_ready));
    expected_results.push_back(nearest_on_segment(it));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_item(logic signed [31:0] qx, logic signed [31:0] qy,
                                         logic signed [31:0] ax, logic signed [31:0] ay,
                                         logic signed [31:0] bx, logic signed [31:0] by);
    in_item_t it;
    it.query_x = qx; it.query_y = qy;
    it.start_x = ax; it.start_y = ay;
    it.end_x   = bx; it.end_y   = by;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord(int scale);
    logic signed [31:0] v;
    v = $urandom();
    case (scale)
      0: return v;
      1: return v >>> 12;
      default: return v >>> 24;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      out_item_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        results_seen++;
        if (exp_r.region <= REGION_END) region_count[exp_r.region]++;
        if (result.nearest_x !== exp_r.nearest_x) begin
          $display("%0t: nearest_x expected %h actual %h", $time, exp_r.nearest_x,
                   result.nearest_x);
          errors++;
        end
        if (result.nearest_y !== exp_r.nearest_y) begin
          $display("%0t: nearest_y expected %h actual %h", $time, exp_r.nearest_y,
                   result.nearest_y);
          errors++;
        end
        if (result.distance !== exp_r.distance) begin
          $display("%0t: distance expected %h actual %h", $time, exp_r.distance,
                   result.distance);
          errors++;
        end
        if (result.region !== exp_r.region) begin
          $display("%0t: region expected %0d actual %0d", $time, exp_r.region,
                   result.region);
          errors++;
        end
      end
    end
  end

  initial begin
    result_ready = 1'b0;
    @(negedge rst);
    forever begin
      int p;
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      p = $urandom_range(99);
      if (!no_idle && p < 50) begin
        result_ready <= 1'b0;
        if (p < 45) repeat ($urandom_range(1, 4)) @(posedge clk);
        else repeat ($urandom_range(20, 120)) @(posedge clk);
      end
    end
  end

  task automatic test_directed();
    send_query(make_item(0, 0, 0, 0, 0, 0));
    send_query(make_item(CMAX, CMAX, 5, -7, 5, -7));
    send_query(make_item(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX));
    send_query(make_item(CMAX, CMIN, CMIN, CMAX, CMIN, CMAX));
    send_query(make_item(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX));
    send_query(make_item(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
    send_query(make_item(0, 0, CMIN, CMIN, CMAX, CMAX));
    send_query(make_item(CMAX, CMIN, CMIN, CMIN, CMAX, CMAX));
    send_query(make_item(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX));
    send_query(make_item(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN));
    send_query(make_item(32'sh10000, 32'sh10000, 0, 0, 32'sh40000, 0));
    send_query(make_item(-32'sh10000, 32'sh30000, 0, 0, 32'sh40000, 0));
    send_query(make_item(32'sh50000, -32'sh20000, 0, 0, 32'sh40000, 0));
    send_query(make_item(7, 9, 7, 9, 100, -3));
    send_query(make_item(100, -3, 7, 9, 100, -3));
    send_query(make_item(CMAX, 0, 0, 0, CMAX, 0));
    send_query(make_item(CMIN, 0, CMIN, 0, 0, 0));
    send_query(make_item(1, 1, 0, 0, 3, 0));
    send_query(make_item(2, 5, 0, 0, 3, 0));
    send_query(make_item(-1, -1, 0, 0, 1, 1));
    send_query(make_item(1, 0, 0, 0, 1, 1));
    send_query(make_item(32'sh12345678, CMIN, 32'shedcba987, 32'sh0f0f0f0f, CMAX, CMIN));
  endtask

  task automatic test_random(int count);
    in_item_t it;
    int kind;
    int sc;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      sc = $urandom_range(2);
      it = make_item(rand_coord(sc), rand_coord(sc), rand_coord(sc), rand_coord(sc),
                     rand_coord(sc), rand_coord(sc));
      case (kind)
        0: begin
          it.end_x = it.start_x; it.end_y = it.start_y;
        end
        1: begin
          it.query_x = it.start_x; it.query_y = it.start_y;
        end
        2: begin
          it.query_x = it.end_x; it.query_y = it.end_y;
        end
        3: begin
          it.end_y = it.start_y;
        end
        4: begin
          it.query_x = it.start_x + ((it.end_x - it.start_x) >>> 1) + rand_coord(2);
          it.query_y = it.start_y + ((it.end_y - it.start_y) >>> 1) + rand_coord(2);
        end
        default: ;
      endcase
      send_query(it);
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_random(count);
    no_idle = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    errors     = 0;
    items_sent = 0;
    results_seen = 0;
    no_idle    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1500);
    test_back_to_back(300);
    test_random(300);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Sent %0d items and checked %0d results under random gaps and stalls.",
             items_sent, results_seen);
    $display("Regions seen: interior %0d, start %0d, end %0d.", region_count[0],
             region_count[1], region_count[2]);
    if (errors == 0) begin
      $display("point_segment_distance_core_tb: PASS");
    end else begin
      $display("point_segment_distance_core_tb: FAIL");
    end
    $finish;
  end

endmodule
